/* hw/rtl/p0sm_pkg.sv */
// Shared types and constants of the PL/0 p-code stack machine core.
// Used by the controller, the datapath, the top level and the testbench scoreboard.
// No dependencies.
package p0sm_pkg;

	localparam int STACK_DEPTH_DEF = 1024;
	localparam int LEVELS_DEF      = 8;
	localparam int CODE_DEPTH_DEF  = 1024;

	localparam int FUNC_W  = 4;
	localparam int ALU_W   = 4;
	localparam int LVL_W   = 3;
	localparam int WORD_W  = 32;
	localparam int ERR_W   = 2;
	localparam int LIMIT_W = 11;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 11'd1004;

	// opcodes
	localparam logic [FUNC_W-1:0] F_LIT = 4'd0;
	localparam logic [FUNC_W-1:0] F_OPR = 4'd1;
	localparam logic [FUNC_W-1:0] F_LOD = 4'd2;
	localparam logic [FUNC_W-1:0] F_STO = 4'd3;
	localparam logic [FUNC_W-1:0] F_CAL = 4'd4;
	localparam logic [FUNC_W-1:0] F_RET = 4'd5;
	localparam logic [FUNC_W-1:0] F_ICT = 4'd6;
	localparam logic [FUNC_W-1:0] F_JMP = 4'd7;
	localparam logic [FUNC_W-1:0] F_JPC = 4'd8;

	// opr operations
	localparam logic [ALU_W-1:0] A_NEG  = 4'd0;
	localparam logic [ALU_W-1:0] A_ADD  = 4'd1;
	localparam logic [ALU_W-1:0] A_SUB  = 4'd2;
	localparam logic [ALU_W-1:0] A_MUL  = 4'd3;
	localparam logic [ALU_W-1:0] A_DIV  = 4'd4;
	localparam logic [ALU_W-1:0] A_ODD  = 4'd5;
	localparam logic [ALU_W-1:0] A_EQ   = 4'd6;
	localparam logic [ALU_W-1:0] A_LS   = 4'd7;
	localparam logic [ALU_W-1:0] A_GR   = 4'd8;
	localparam logic [ALU_W-1:0] A_NEQ  = 4'd9;
	localparam logic [ALU_W-1:0] A_LSEQ = 4'd10;
	localparam logic [ALU_W-1:0] A_GREQ = 4'd11;
	localparam logic [ALU_W-1:0] A_WRT  = 4'd12;
	localparam logic [ALU_W-1:0] A_WRL  = 4'd13;

	// error codes
	localparam logic [ERR_W-1:0] E_NONE = 2'd0;
	localparam logic [ERR_W-1:0] E_OVF  = 2'd1;
	localparam logic [ERR_W-1:0] E_DIV0 = 2'd2;
	localparam logic [ERR_W-1:0] E_ADDR = 2'd3;

	typedef enum logic [2:0] {
		AS_TOP, AS_TOPM1, AS_TOPP1, AS_FRAME, AS_BASE, AS_BASEP1
	} asel_t;

	typedef enum logic [2:0] {
		WS_OPND, WS_RD, WS_X, WS_DISP, WS_LINK, WS_ALU, WS_QUO
	} wsel_t;

	typedef enum logic [2:0] {
		TO_HOLD, TO_INC, TO_DEC, TO_RET, TO_ICT
	} top_op_t;

	typedef enum logic {
		CM_OPND, CM_RD
	} cmod_src_t;

	typedef struct packed {
		logic      capture;
		logic      rd;
		logic      wr;
		asel_t     asel;
		wsel_t     wsel;
		top_op_t   top_op;
		logic      lat_x;
		logic      lat_b;
		logic      lat_base;
		logic      lat_print;
		logic      set_nl;
		logic      alu_exec;
		logic      div_start;
		cmod_src_t cmod_src;
		logic      set_disp_cal;
		logic      set_disp_ret;
		logic      ld_next;
		logic      next_if_zero;
		logic      load_out;
	} p0sm_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ALU_W-1:0]  alu_op;
		logic              b_zero;
		logic              div_done;
		logic              out_free;
	} p0sm_stat_t;

endpackage

/* hw/rtl/pl0_stack_machine_core.sv */
// Top level of the PL/0 p-code stack machine core: stream ports, controller and datapath.
// Depends on p0sm_pkg, p0sm_ctrl and p0sm_dp.
//
//   channel | direction | contents
//   --------+-----------+-----------------------------------------------------------
//   s_*     | in        | one p-code instruction per transaction
//   m_*     | out       | one result per instruction: next pc, print, newline, halt, error
//   cfg_*   | in        | stack_limit write, taken on any edge with cfg_we high
//
// Each instruction walks through its own sequence of controller steps; the single
// stack memory port (one access per cycle, registered read) and the one-bit-per-cycle
// divider, on which div by a nonzero divisor waits, pace them. One instruction is in
// flight at a time; the next is taken once the result sits in the output register,
// and loading that register waits while an earlier result is held by m_tready low.
// Reset clears top, pc, display, stack_limit (1004) and the output valid; stack words
// 0 and 1 read as zero until written.
module pl0_stack_machine_core #(
	parameter int STACK_DEPTH = p0sm_pkg::STACK_DEPTH_DEF,
	parameter int LEVELS      = p0sm_pkg::LEVELS_DEF,
	parameter int CODE_DEPTH  = p0sm_pkg::CODE_DEPTH_DEF,
	localparam int PC_W       = $clog2(CODE_DEPTH),
	localparam int OUT_TW     = ((PC_W + 35) + 7) / 8 * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [39:0]                  s_tdata,  // level[2:0], operand[34:3]
	input  logic [7:0]                   s_tuser,  // func[3:0], alu_op[7:4]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [OUT_TW-1:0]            m_tdata,  // next_pc, print_value, newline, halted, error
	output logic [0:0]                   m_tuser,  // print_valid
	input  logic                         cfg_we,
	input  logic [p0sm_pkg::LIMIT_W-1:0] cfg_wdata
);
	import p0sm_pkg::*;

	p0sm_cmd_t  cmd;
	p0sm_stat_t st;

	logic [PC_W-1:0]    next_pc;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic               newline, halted;
	logic [ERR_W-1:0]   error;

	// sequence the steps of each instruction
	p0sm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// capture happens on the accepting edge: cmd.capture only rises in idle with tvalid
	p0sm_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.LEVELS      (LEVELS),
		.CODE_DEPTH  (CODE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_func         (s_tuser[3:0]),
		.in_alu_op       (s_tuser[7:4]),
		.in_level        (s_tdata[2:0]),
		.in_operand      (s_tdata[34:3]),
		.cmd             (cmd),
		.st              (st),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_next_pc     (next_pc),
		.out_print_valid (print_valid),
		.out_print_value (print_value),
		.out_newline     (newline),
		.out_halted      (halted),
		.out_error       (error)
	);

	// pack the result transaction, lowest field first
	assign m_tdata = OUT_TW'({error, halted, newline, print_value, next_pc});
	assign m_tuser = print_valid;

endmodule

/* hw/rtl/p0sm_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module p0sm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* hw/rtl/p0sm_modc.sv */
// Two-stage reduction of a 32-bit unsigned value modulo a constant.
// Mask for a power of two, reciprocal multiply and correction otherwise.
// No dependencies.
module p0sm_modc #(
	parameter int DIVISOR = 1024
) (
	input  logic                       clk,
	input  logic [31:0]                val,
	output logic [$clog2(DIVISOR)-1:0] res
);

	localparam int K = $clog2(DIVISOR);

	generate
		if ((1 << K) == DIVISOR) begin : g_pow2
			logic [K-1:0] v_s1;
			always_ff @(posedge clk) begin
				v_s1 <= val[K-1:0];
				res  <= v_s1;
			end
		end else begin : g_recip
			localparam longint unsigned MUL = (64'd1 << (32 + K)) / 64'(DIVISOR);
			localparam logic [32:0] MUL_C = 33'(MUL);
			localparam logic [33:0] D_C = 34'(DIVISOR);
			logic [64:0] prod;
			logic [31:0] q_s1;
			logic [31:0] v_s1;
			logic [49:0] qd;
			logic [33:0] r;
			assign prod = 65'(val) * 65'(MUL_C);
			// the estimate is the quotient or one less
			assign qd = 50'(q_s1) * 50'(DIVISOR);
			assign r  = 34'(50'(v_s1) - qd);
			always_ff @(posedge clk) begin
				q_s1 <= 32'(prod >> (32 + K));
				v_s1 <= val;
				res  <= (r >= D_C) ? K'(r - D_C) : K'(r);
			end
		end
	endgenerate

endmodule

/* hw/rtl/p0sm_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// No dependencies.
module p0sm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [32:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q[31:0], quo_q[31]};
	assign fits   = rem_sh >= {1'b0, dvs_q};
	assign done   = done_q;
	assign quot   = neg_q ? 32'(-quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? 32'(-dividend) : dividend;
			dvs_q <= divisor[31] ? 32'(-divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q <= {quo_q[30:0], fits};
		end
	end

endmodule

/* hw/rtl/p0sm_ctrl.sv */
// Sequencer of the stack machine: walks each instruction through its steps.
// Depends on p0sm_pkg.
module p0sm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  p0sm_pkg::p0sm_stat_t st,
	output p0sm_pkg::p0sm_cmd_t  cmd
);
	import p0sm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DEC, S_LOD2, S_STO2, S_CAL2, S_CAL3, S_JWAIT, S_JPC2, S_JLOAD,
		S_RET2, S_RET3, S_RET4, S_RET5, S_RET6, S_BIN2, S_ALU, S_WRB, S_DIVW,
		S_WRT2, S_FIN
	} state_t;

	state_t state_q, state_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = S_DEC;
				end
			end
			S_DEC: begin
				state_n = S_FIN;
				unique case (st.func)
					F_LIT: begin
						cmd.wr = 1'b1; cmd.asel = AS_TOP; cmd.wsel = WS_OPND;
						cmd.top_op = TO_INC;
					end
					F_LOD: begin
						cmd.rd = 1'b1; cmd.asel = AS_FRAME; state_n = S_LOD2;
					end
					F_STO: begin
						cmd.rd = 1'b1; cmd.asel = AS_TOPM1; cmd.top_op = TO_DEC;
						state_n = S_STO2;
					end
					F_CAL: begin
						cmd.wr = 1'b1; cmd.asel = AS_TOP; cmd.wsel = WS_DISP;
						state_n = S_CAL2;
					end
					F_RET: begin
						cmd.rd = 1'b1; cmd.asel = AS_TOPM1; cmd.top_op = TO_DEC;
						cmd.lat_base = 1'b1; state_n = S_RET2;
					end
					F_ICT: cmd.top_op = TO_ICT;
					F_JMP: state_n = S_JWAIT;
					F_JPC: begin
						cmd.rd = 1'b1; cmd.asel = AS_TOPM1; cmd.top_op = TO_DEC;
						state_n = S_JPC2;
					end
					F_OPR: begin
						unique case (st.alu_op) inside
							A_NEG, A_ODD: begin
								cmd.rd = 1'b1; cmd.asel = AS_TOPM1; state_n = S_ALU;
							end
							A_WRT: begin
								cmd.rd = 1'b1; cmd.asel = AS_TOPM1; cmd.top_op = TO_DEC;
								state_n = S_WRT2;
							end
							A_WRL: cmd.set_nl = 1'b1;
							A_ADD, A_SUB, A_MUL, A_DIV, A_EQ, A_LS, A_GR, A_NEQ,
							A_LSEQ, A_GREQ: begin
								cmd.rd = 1'b1; cmd.asel = AS_TOPM1; cmd.top_op = TO_DEC;
								state_n = S_BIN2;
							end
							default: state_n = S_FIN;
						endcase
					end
					default: state_n = S_FIN;
				endcase
			end
			S_LOD2: begin
				cmd.wr = 1'b1; cmd.asel = AS_TOP; cmd.wsel = WS_RD; cmd.top_op = TO_INC;
				state_n = S_FIN;
			end
			S_STO2: begin
				cmd.wr = 1'b1; cmd.asel = AS_FRAME; cmd.wsel = WS_RD;
				state_n = S_FIN;
			end
			S_CAL2: begin
				cmd.wr = 1'b1; cmd.asel = AS_TOPP1; cmd.wsel = WS_LINK;
				cmd.set_disp_cal = 1'b1;
				state_n = S_CAL3;
			end
			S_CAL3: begin
				cmd.ld_next = 1'b1;
				state_n     = S_FIN;
			end
			S_JWAIT: state_n = S_JLOAD;
			S_JPC2: begin
				cmd.lat_x = 1'b1;
				state_n   = S_JLOAD;
			end
			S_JLOAD: begin
				cmd.ld_next      = 1'b1;
				cmd.next_if_zero = (st.func == F_JPC);
				state_n          = S_FIN;
			end
			S_RET2: begin
				cmd.lat_x = 1'b1; cmd.rd = 1'b1; cmd.asel = AS_BASE;
				state_n = S_RET3;
			end
			S_RET3: begin
				cmd.rd = 1'b1; cmd.asel = AS_BASEP1;
				state_n = S_RET4;
			end
			S_RET4: begin
				cmd.cmod_src = CM_RD; cmd.top_op = TO_RET;
				state_n = S_RET5;
			end
			S_RET5: begin
				cmd.set_disp_ret = 1'b1;
				cmd.wr = 1'b1; cmd.asel = AS_TOP; cmd.wsel = WS_X; cmd.top_op = TO_INC;
				state_n = S_RET6;
			end
			S_RET6: begin
				cmd.ld_next = 1'b1;
				state_n     = S_FIN;
			end
			S_BIN2: begin
				cmd.lat_b = 1'b1; cmd.rd = 1'b1; cmd.asel = AS_TOPM1;
				state_n = S_ALU;
			end
			S_ALU: begin
				cmd.alu_exec = 1'b1; cmd.lat_x = 1'b1;
				state_n = S_WRB;
			end
			S_WRB: begin
				if (st.alu_op == A_DIV && !st.b_zero) begin
					cmd.div_start = 1'b1;
					state_n       = S_DIVW;
				end else begin
					cmd.wr = 1'b1; cmd.asel = AS_TOPM1; cmd.wsel = WS_ALU;
					state_n = S_FIN;
				end
			end
			S_DIVW: begin
				if (st.div_done) begin
					cmd.wr = 1'b1; cmd.asel = AS_TOPM1; cmd.wsel = WS_QUO;
					state_n = S_FIN;
				end
			end
			S_WRT2: begin
				cmd.lat_print = 1'b1;
				state_n       = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

/* hw/rtl/p0sm_dp.sv */
// Datapath of the stack machine: stack memory, display, top, pc, ALU, result register.
// Depends on p0sm_pkg, p0sm_ram, p0sm_modc and p0sm_div.
module p0sm_dp #(
	parameter int STACK_DEPTH = p0sm_pkg::STACK_DEPTH_DEF,
	parameter int LEVELS      = p0sm_pkg::LEVELS_DEF,
	parameter int CODE_DEPTH  = p0sm_pkg::CODE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [p0sm_pkg::LIMIT_W-1:0]        cfg_wdata,
	input  logic [p0sm_pkg::FUNC_W-1:0]         in_func,
	input  logic [p0sm_pkg::ALU_W-1:0]          in_alu_op,
	input  logic [p0sm_pkg::LVL_W-1:0]          in_level,
	input  logic signed [p0sm_pkg::WORD_W-1:0]  in_operand,
	input  p0sm_pkg::p0sm_cmd_t                 cmd,
	output p0sm_pkg::p0sm_stat_t                st,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [$clog2(CODE_DEPTH)-1:0]       out_next_pc,
	output logic                                out_print_valid,
	output logic signed [p0sm_pkg::WORD_W-1:0]  out_print_value,
	output logic                                out_newline,
	output logic                                out_halted,
	output logic [p0sm_pkg::ERR_W-1:0]          out_error
);
	import p0sm_pkg::*;

	localparam int SAW  = $clog2(STACK_DEPTH);
	localparam int TW   = SAW + 1;
	localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PC_W = $clog2(CODE_DEPTH);
	localparam logic signed [33:0] SD_S = 34'(STACK_DEPTH);

	logic [TW-1:0]     top_q;
	logic [PC_W-1:0]   pc_q;
	logic [PC_W-1:0]   next_q;
	logic [SAW-1:0]    disp_q [LEVELS];
	logic [SAW-1:0]    base_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [1:0]        w01_q;
	logic              rd_mask_q;
	logic              fault_q, ovf_q, div0_q;
	logic [FUNC_W-1:0] func_q;
	logic [ALU_W-1:0]  alu_q;
	logic [LW-1:0]     lvl_q;
	logic [31:0]       opw_q, x_q, b_q, res_q, pv_q;
	logic              pvalid_q, nl_q;

	logic [5:0]        lvl_m;
	logic [LW-1:0]     cl;
	logic signed [33:0] top_s, opnd_s, base_s, addr_s, nt;
	logic              addr_fault, nt_fault;
	logic [31:0]       ram_rdata, rdata, wdata, alu_n, cmod_in, quot;
	logic [PC_W-1:0]   cmod_res;
	logic [SAW-1:0]    smod_res;
	logic              div_done;

	assign top_s  = signed'(34'(top_q));
	assign opnd_s = 34'(signed'(opw_q));
	assign base_s = signed'(34'(base_q));
	assign cl     = (lvl_q == LW'(LEVELS - 1)) ? '0 : lvl_q + 1'b1;
	assign rdata  = rd_mask_q ? '0 : ram_rdata;

	// fold the 3-bit level into the display range
	always_comb begin
		lvl_m = 6'(in_level);
		for (int i = 0; i < 3; i++) begin
			if (lvl_m >= 6'(LEVELS)) begin
				lvl_m = lvl_m - 6'(LEVELS);
			end
		end
	end

	always_comb begin
		case (cmd.asel)
			AS_TOP:    addr_s = top_s;
			AS_TOPM1:  addr_s = top_s - 34'sd1;
			AS_TOPP1:  addr_s = top_s + 34'sd1;
			AS_FRAME:  addr_s = signed'(34'(disp_q[lvl_q])) + opnd_s;
			AS_BASE:   addr_s = base_s;
			AS_BASEP1: addr_s = base_s + 34'sd1;
			default:   addr_s = top_s;
		endcase
		addr_fault = (addr_s < 34'sd0) || (addr_s >= SD_S);
	end

	always_comb begin
		case (cmd.wsel)
			WS_OPND: wdata = opw_q;
			WS_RD:   wdata = rdata;
			WS_X:    wdata = x_q;
			WS_DISP: wdata = 32'(disp_q[cl]);
			WS_LINK: wdata = 32'(next_q);
			WS_ALU:  wdata = res_q;
			WS_QUO:  wdata = quot;
			default: wdata = opw_q;
		endcase
	end

	// new top for ict (from top) and ret (from the frame base), clamped
	always_comb begin
		nt       = (cmd.top_op == TO_ICT) ? top_s + opnd_s : base_s - opnd_s;
		nt_fault = 1'b0;
		if (nt < 34'sd0) begin
			nt       = '0;
			nt_fault = 1'b1;
		end
	end

	always_comb begin
		case (alu_q)
			A_NEG:   alu_n = 32'(-rdata);
			A_ODD:   alu_n = {31'd0, rdata[0]};
			A_ADD:   alu_n = rdata + b_q;
			A_SUB:   alu_n = rdata - b_q;
			A_MUL:   alu_n = rdata * b_q;
			A_EQ:    alu_n = {31'd0, rdata == b_q};
			A_LS:    alu_n = {31'd0, signed'(rdata) < signed'(b_q)};
			A_GR:    alu_n = {31'd0, signed'(rdata) > signed'(b_q)};
			A_NEQ:   alu_n = {31'd0, rdata != b_q};
			A_LSEQ:  alu_n = {31'd0, signed'(rdata) <= signed'(b_q)};
			A_GREQ:  alu_n = {31'd0, signed'(rdata) >= signed'(b_q)};
			default: alu_n = '0;
		endcase
	end

	assign cmod_in = (cmd.cmod_src == CM_RD) ? rdata : opw_q;

	p0sm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (cmd.wr && !addr_fault),
		.addr  (addr_s[SAW-1:0]),
		.wdata (wdata),
		.rdata (ram_rdata)
	);

	p0sm_modc #(.DIVISOR(CODE_DEPTH)) u_cmod (
		.clk (clk),
		.val (cmod_in),
		.res (cmod_res)
	);

	p0sm_modc #(.DIVISOR(STACK_DEPTH)) u_smod (
		.clk (clk),
		.val (rdata),
		.res (smod_res)
	);

	p0sm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (x_q),
		.divisor  (b_q),
		.done     (div_done),
		.quot     (quot)
	);

	assign st.func     = func_q;
	assign st.alu_op   = alu_q;
	assign st.b_zero   = (b_q == '0);
	assign st.div_done = div_done;
	assign st.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			pc_q      <= '0;
			limit_q   <= LIMIT_RST;
			w01_q     <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				disp_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.wr && !addr_fault && addr_s < 34'sd2) begin
				w01_q[addr_s[0]] <= 1'b1;
			end
			case (cmd.top_op)
				TO_INC: if (top_q != TW'(STACK_DEPTH)) top_q <= top_q + 1'b1;
				TO_DEC: if (top_q != '0) top_q <= top_q - 1'b1;
				TO_RET, TO_ICT: top_q <= (nt > SD_S) ? TW'(STACK_DEPTH) : TW'(nt);
				default: ;
			endcase
			if (cmd.set_disp_cal) begin
				disp_q[cl] <= (top_q == TW'(STACK_DEPTH)) ? '0 : top_q[SAW-1:0];
			end
			if (cmd.set_disp_ret) begin
				disp_q[lvl_q] <= smod_res;
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
				pc_q      <= next_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_mask_q <= addr_fault || (addr_s < 34'sd2 && !w01_q[addr_s[0]]);
		if (cmd.capture) begin
			func_q   <= in_func;
			alu_q    <= in_alu_op;
			lvl_q    <= LW'(lvl_m);
			opw_q    <= in_operand;
			next_q   <= (pc_q == PC_W'(CODE_DEPTH - 1)) ? '0 : pc_q + 1'b1;
			fault_q  <= 1'b0;
			ovf_q    <= 1'b0;
			div0_q   <= 1'b0;
			pvalid_q <= 1'b0;
			pv_q     <= '0;
			nl_q     <= 1'b0;
		end else begin
			if ((cmd.rd || cmd.wr) && addr_fault) begin
				fault_q <= 1'b1;
			end
			if (cmd.top_op == TO_RET) begin
				if (nt_fault || nt > SD_S) fault_q <= 1'b1;
			end
			if (cmd.top_op == TO_ICT) begin
				if (nt_fault) fault_q <= 1'b1;
				if (nt >= signed'(34'(limit_q))) ovf_q <= 1'b1;
			end
			if (cmd.ld_next && (!cmd.next_if_zero || x_q == '0)) begin
				next_q <= cmod_res;
			end
			if (cmd.alu_exec && alu_q == A_DIV && b_q == '0) begin
				div0_q <= 1'b1;
			end
			if (cmd.set_nl) nl_q <= 1'b1;
			if (cmd.lat_print) begin
				pv_q     <= rdata;
				pvalid_q <= 1'b1;
			end
		end
		if (cmd.lat_base) base_q <= disp_q[lvl_q];
		if (cmd.lat_x)    x_q    <= rdata;
		if (cmd.lat_b)    b_q    <= rdata;
		if (cmd.alu_exec) res_q  <= alu_n;
		if (cmd.load_out) begin
			out_next_pc     <= next_q;
			out_print_valid <= pvalid_q;
			out_print_value <= pv_q;
			out_newline     <= nl_q;
			out_halted      <= (next_q == '0);
			out_error       <= fault_q ? E_ADDR : ovf_q ? E_OVF : div0_q ? E_DIV0 : E_NONE;
		end
	end

endmodule

/* tb/pl0_stack_machine_core_chk.sv */
// Scoreboard for the PL/0 stack machine core: watches the instruction, result and
// configuration channels, predicts each result and compares it. Depends on p0sm_pkg.
module pl0_stack_machine_core_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [39:0]                   s_tdata,
	input  logic [7:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [47:0]                   m_tdata,
	input  logic [0:0]                    m_tuser,
	input  logic                          cfg_we,
	input  logic [p0sm_pkg::LIMIT_W-1:0]  cfg_wdata,
	output int                            pending,
	output int                            fail_count
);
	import p0sm_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;

	typedef struct packed {
		logic [9:0]        next_pc;
		logic              print_valid;
		logic [WORD_W-1:0] print_value;
		logic              newline;
		logic              halted;
		logic [ERR_W-1:0]  error;
	} outcome_t;

	logic [WORD_W-1:0]  stack_mem [0:DEPTH-1];
	logic [9:0]         frame_base [0:LEVELS_DEF-1];
	int                 top_ptr;
	logic [9:0]         pc;
	logic [LIMIT_W-1:0] limit;
	logic               addr_fault;
	outcome_t           expected_q[$];

	assign pending = expected_q.size();

	function automatic logic [WORD_W-1:0] stack_rd(longint a);
		if (a < 0 || a >= DEPTH) begin
			addr_fault = 1'b1;
			return '0;
		end
		return stack_mem[a];
	endfunction

	function automatic void stack_wr(longint a, logic [WORD_W-1:0] v);
		if (a < 0 || a >= DEPTH)
			addr_fault = 1'b1;
		else
			stack_mem[a] = v;
	endfunction

	function automatic void push_word(logic [WORD_W-1:0] v);
		stack_wr(top_ptr, v);
		if (top_ptr < DEPTH)
			top_ptr++;
	endfunction

	function automatic logic [WORD_W-1:0] pop_word();
		if (top_ptr == 0) begin
			addr_fault = 1'b1;
			return '0;
		end
		top_ptr--;
		return stack_mem[top_ptr];
	endfunction

	// Execute one instruction against the shadow machine state.
	function automatic outcome_t execute(logic [3:0] fn, logic [3:0] op, logic [2:0] lvl,
			logic [WORD_W-1:0] opw);
		outcome_t o;
		logic [9:0] nxt;
		logic [WORD_W-1:0] a, b, r;
		logic [9:0] base;
		longint sa, sb, nt, opnd;
		int cl;
		o = '0;
		nxt = pc + 10'd1;
		opnd = longint'($signed(opw));
		addr_fault = 1'b0;
		case (fn)
			F_LIT: push_word(opw);
			F_LOD: push_word(stack_rd(longint'(frame_base[lvl]) + opnd));
			F_STO: begin
				a = pop_word();
				stack_wr(longint'(frame_base[lvl]) + opnd, a);
			end
			F_CAL: begin
				cl = (lvl + 1) % LEVELS_DEF;
				stack_wr(top_ptr, {22'd0, frame_base[cl]});
				stack_wr(top_ptr + 1, {22'd0, nxt});
				frame_base[cl] = 10'(top_ptr % DEPTH);
				nxt = opw[9:0];
			end
			F_RET: begin
				a = pop_word();
				base = frame_base[lvl];
				frame_base[lvl] = 10'(stack_rd(longint'(base)) % DEPTH);
				nxt = 10'(stack_rd(longint'(base) + 1) % 1024);
				nt = longint'(base) - opnd;
				if (nt < 0) begin
					addr_fault = 1'b1;
					nt = 0;
				end
				if (nt > DEPTH) begin
					addr_fault = 1'b1;
					nt = DEPTH;
				end
				top_ptr = int'(nt);
				push_word(a);
			end
			F_ICT: begin
				nt = top_ptr + opnd;
				if (nt < 0) begin
					addr_fault = 1'b1;
					nt = 0;
				end
				if (nt >= longint'(limit))
					o.error = E_OVF;
				if (nt > DEPTH)
					nt = DEPTH;
				top_ptr = int'(nt);
			end
			F_JMP: nxt = opw[9:0];
			F_JPC: if (pop_word() == '0) nxt = opw[9:0];
			F_OPR: begin
				if (op == A_NEG) begin
					a = stack_rd(top_ptr - 1);
					stack_wr(top_ptr - 1, -a);
				end else if (op == A_ODD) begin
					a = stack_rd(top_ptr - 1);
					stack_wr(top_ptr - 1, {31'd0, a[0]});
				end else if (op == A_WRT) begin
					o.print_value = pop_word();
					o.print_valid = 1'b1;
				end else if (op == A_WRL) begin
					o.newline = 1'b1;
				end else if (op <= A_GREQ) begin
					b = pop_word();
					a = stack_rd(top_ptr - 1);
					sa = longint'($signed(a));
					sb = longint'($signed(b));
					case (op)
						A_ADD:  r = a + b;
						A_SUB:  r = a - b;
						A_MUL:  r = a * b;
						A_DIV: begin
							if (b == '0) begin
								r = '0;
								o.error = E_DIV0;
							end else begin
								nt = sa / sb;
								r = nt[31:0];
							end
						end
						A_EQ:   r = {31'd0, sa == sb};
						A_LS:   r = {31'd0, sa < sb};
						A_GR:   r = {31'd0, sa > sb};
						A_NEQ:  r = {31'd0, sa != sb};
						A_LSEQ: r = {31'd0, sa <= sb};
						default: r = {31'd0, sa >= sb};
					endcase
					stack_wr(top_ptr - 1, r);
				end
			end
			default: ;
		endcase
		if (addr_fault)
			o.error = E_ADDR;
		pc = nxt;
		o.next_pc = nxt;
		o.halted = (nxt == 10'd0);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				stack_mem[i] = '0;
			for (int i = 0; i < LEVELS_DEF; i++)
				frame_base[i] = '0;
			top_ptr = 0;
			pc = '0;
			limit = LIMIT_RST;
			expected_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we)
				limit = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got.next_pc = m_tdata[9:0];
				got.print_value = m_tdata[41:10];
				got.newline = m_tdata[42];
				got.halted = m_tdata[43];
				got.error = m_tdata[45:44];
				got.print_valid = m_tuser[0];
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got.next_pc !== want.next_pc || got.print_valid !== want.print_valid ||
							got.print_value !== want.print_value ||
							got.newline !== want.newline || got.halted !== want.halted ||
							got.error !== want.error) begin
						$display("%0t: mismatch exp pc=%0d pv=%b val=%h nl=%b h=%b err=%0d",
							$time, want.next_pc, want.print_valid, want.print_value,
							want.newline, want.halted, want.error);
						$display("%0t:          got pc=%0d pv=%b val=%h nl=%b h=%b err=%0d",
							$time, got.next_pc, got.print_valid, got.print_value,
							got.newline, got.halted, got.error);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(execute(s_tuser[3:0], s_tuser[7:4], s_tdata[2:0],
					s_tdata[34:3]));
		end
	end
endmodule

/* tb/pl0_stack_machine_core_tb.sv */
// Testbench top for pl0_stack_machine_core: clock, reset, instruction stimulus and verdict.
// Depends on p0sm_pkg, pl0_stack_machine_core and pl0_stack_machine_core_chk.
module pl0_stack_machine_core_tb;
	import p0sm_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [39:0]        s_tdata = '0;
	logic [7:0]         s_tuser = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [47:0]        m_tdata;
	logic [0:0]         m_tuser;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;
	int                 pending, fail_count;
	int                 idle_pct = 0, stall_pct = 0, sent = 0;

	pl0_stack_machine_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	pl0_stack_machine_core_chk chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .pending(pending), .fail_count(fail_count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver back-pressure at the current stall rate.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Present one instruction, hold it until the transaction completes, then idle at random.
	task automatic issue(logic [3:0] fn, logic [3:0] op, logic [2:0] lvl, logic [31:0] opnd);
		s_tvalid <= 1'b1;
		s_tuser <= {op, fn};
		s_tdata <= {5'd0, opnd, lvl};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		sent++;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	// Write stack_limit while the core is idle.
	task automatic set_limit(logic [LIMIT_W-1:0] v);
		drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Draw one instruction: mostly well-formed with small offsets, some raw noise.
	task automatic random_instr();
		logic [3:0] fn, op;
		logic [2:0] lvl;
		logic [31:0] opnd;
		int pick;
		pick = $urandom_range(99);
		op = 4'($urandom_range(13));
		lvl = 3'($urandom_range(7));
		fn = 4'($urandom_range(8));
		if (pick < 10) begin
			fn = 4'($urandom);
			op = 4'($urandom);
			opnd = $urandom;
		end else begin
			case (fn)
				F_LIT:   opnd = $urandom_range(1) ? $urandom : $urandom_range(20) - 10;
				F_LOD, F_STO: opnd = $urandom_range(8) - 2;
				F_ICT:   opnd = $urandom_range(11) - 6;
				F_RET:   opnd = $urandom_range(3);
				default: opnd = $urandom_range(1023);
			endcase
			// Bias toward arithmetic and pushes to keep the stack populated.
			if (pick < 45)
				fn = F_OPR;
			else if (pick < 70)
				fn = F_LIT;
		end
		issue(fn, op, lvl, opnd);
	endtask

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		logic [LIMIT_W-1:0] phase_limit[4];
		phase_idle[0] = 0;
		phase_idle[1] = 70;
		phase_idle[2] = 0;
		phase_idle[3] = 70;
		phase_stall[0] = 0;
		phase_stall[1] = 0;
		phase_stall[2] = 70;
		phase_stall[3] = 70;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole stack so that no later read hits an unwritten word.
		for (int i = 0; i < STACK_DEPTH_DEF; i++)
			issue(F_LIT, A_NEG, 3'd0, $urandom);
		issue(F_ICT, A_NEG, 3'd0, -32'sd1024);

		set_limit(11'd1024);
		issue(F_LIT, A_NEG, 3'd0, 32'h8000_0000);
		issue(F_LIT, A_NEG, 3'd0, 32'hFFFF_FFFF);
		issue(F_OPR, A_DIV, 3'd0, '0);           // quotient overflow wraps
		issue(F_LIT, A_NEG, 3'd0, 32'd5);
		issue(F_LIT, A_NEG, 3'd0, 32'd0);
		issue(F_OPR, A_DIV, 3'd0, '0);           // divide by zero
		issue(F_OPR, A_NEG, 3'd0, '0);
		issue(F_OPR, A_ODD, 3'd0, '0);
		issue(F_OPR, A_WRT, 3'd0, '0);
		issue(F_OPR, A_WRL, 3'd0, '0);
		issue(F_OPR, A_WRT, 3'd0, '0);
		issue(F_OPR, A_WRT, 3'd0, '0);           // pop on empty stack
		issue(F_ICT, A_NEG, 3'd0, -32'sd5);      // clamp below zero
		issue(F_ICT, A_NEG, 3'd0, 32'd2000);     // clamp to full, overflow
		issue(F_LIT, A_NEG, 3'd0, 32'h7FFF_FFFF); // push on full stack
		issue(F_ICT, A_NEG, 3'd0, -32'sd1024);
		issue(F_CAL, A_NEG, 3'd7, 32'hFFFF_FFFF); // level wrap, target wrap
		issue(F_LOD, A_NEG, 3'd0, 32'hFFFF_FFFF); // address below zero
		issue(F_STO, A_NEG, 3'd0, 32'd2000);      // address past the end
		issue(F_JMP, A_NEG, 3'd0, 32'd1024);      // halt via target wrap
		issue(F_JPC, A_NEG, 3'd0, 32'hFFFF_FFFF);
		issue(F_RET, A_NEG, 3'd0, 32'h8000_0000);
		issue(4'hF, 4'hF, 3'd5, 32'h5555_AAAA);   // undefined opcode
		issue(F_OPR, 4'hF, 3'd2, 32'hAAAA_5555);  // undefined opr
		issue(F_LOD, A_NEG, 3'd3, 32'h7FFF_FFFF);

		phase_limit[0] = 11'd1;
		phase_limit[1] = 11'($urandom_range(1024, 1));
		phase_limit[2] = 11'd1004;
		phase_limit[3] = 11'd1024;
		for (int p = 0; p < 4; p++) begin
			set_limit(phase_limit[p]);
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < 112; n++) begin
				if (p == 1 && n == 56) begin
					s_tvalid <= 1'b0;
					drain();
				end
				if (p == 3 && n == 80) begin
					idle_pct = 9;
					stall_pct = 9;
				end
				random_instr();
			end
		end
		s_tvalid <= 1'b0;
		stall_pct = 0;
		drain();
		repeat (60) @(posedge clk);

		$display("Ran %0d instructions over all opcodes, four stack limits and four", sent);
		$display("back-pressure phases, after a full stack fill.");
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", pending);
		$display("CHECK FAILED");
		$finish;
	end
endmodule
